// ===== rtl/tpid_pkg.sv =====
// shared widths, constants and stage word types for the tilt pid controller
package tpid_pkg;

  localparam int TILT_W  = 17;
  localparam int ERR_W   = 18;
  localparam int DIFF_W  = 19;
  localparam int INTEG_W = 23;
  localparam int KP_W    = 15;
  localparam int KI_W    = 12;
  localparam int KD_W    = 12;
  localparam int CFG_W   = 15;
  localparam int IDX_W   = 2;

  // prescaled gains: kp * 100 and kd * 10000
  localparam int KPS_W = 22;
  localparam int KDS_W = 26;

  localparam int P_W   = KPS_W + 1 + ERR_W;
  localparam int I_W   = KI_W + 1 + INTEG_W;
  localparam int D_W   = KDS_W + 1 + DIFF_W;
  localparam int NUM_W = D_W + 1;

  localparam int QIN_W = 15;
  localparam int RECIP_W = 13;
  localparam int RECIP_SH = 19;
  localparam int VAL_W = 9;
  localparam int DRV_W = 8;

  localparam logic [KPS_W-1:0] KPS_RESET = KPS_W'(7680 * 100);
  localparam logic [KI_W-1:0]  KI_RESET  = KI_W'(128);
  localparam logic [KDS_W-1:0] KDS_RESET = KDS_W'(384 * 10000);

  localparam logic [6:0]  P_SCALE = 7'd100;
  localparam logic [13:0] D_SCALE = 14'd10000;

  localparam logic signed [INTEG_W:0] INTEG_LIM = (INTEG_W+1)'(2560000);
  localparam logic signed [TILT_W-1:0] STOP_ANGLE = TILT_W'(11520);
  localparam logic signed [NUM_W-1:0] SUM_LIM = NUM_W'(64'd1671168000);
  // ceil(2^19 / 100), exact floor for quotient inputs below 25600
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
  localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'(255);
  localparam logic signed [VAL_W-1:0] DRV_MAX = VAL_W'(127);

  typedef enum logic [IDX_W-1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [KPS_W-1:0] kps;
    logic [KI_W-1:0]  ki;
    logic [KDS_W-1:0] kds;
  } gains_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DIFF_W-1:0]  diff;
    logic                      stop;
  } front_t;

  typedef struct packed {
    logic signed [P_W-1:0] p;
    logic signed [I_W-1:0] i;
    logic signed [D_W-1:0] d;
    logic                  stop;
  } prod_t;

  typedef struct packed {
    logic              sat_hi;
    logic              sat_lo;
    logic              neg;
    logic [QIN_W-1:0]  qin;
    logic              stop;
  } red_t;

endpackage

// ===== rtl/tpid_cfg.sv =====
// gain registers, stored prescaled for the product stage
module tpid_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tpid_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tpid_pkg::CFG_W-1:0]     cfg_wdata,
  output tpid_pkg::gains_t               gains
);

  tpid_pkg::gains_t gains_r;
  tpid_pkg::gains_t gains_nxt;

  always_comb begin
    gains_nxt = gains_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tpid_pkg::REG_PROP:
          gains_nxt.kps = tpid_pkg::KPS_W'(cfg_wdata[tpid_pkg::KP_W-1:0])
                        * tpid_pkg::KPS_W'(tpid_pkg::P_SCALE);
        tpid_pkg::REG_INTEG:
          gains_nxt.ki = cfg_wdata[tpid_pkg::KI_W-1:0];
        tpid_pkg::REG_DERIV:
          gains_nxt.kds = tpid_pkg::KDS_W'(cfg_wdata[tpid_pkg::KD_W-1:0])
                        * tpid_pkg::KDS_W'(tpid_pkg::D_SCALE);
        default: gains_nxt = gains_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.kps <= tpid_pkg::KPS_RESET;
      gains_r.ki  <= tpid_pkg::KI_RESET;
      gains_r.kds <= tpid_pkg::KDS_RESET;
    end else begin
      gains_r <= gains_nxt;
    end
  end

  assign gains = gains_r;

endmodule

// ===== rtl/tpid_front.sv =====
// input stage: target capture, error, clamped integral, error difference, tilt stop
module tpid_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [tpid_pkg::TILT_W-1:0]   tilt,
  input  logic                                 capture,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output tpid_pkg::front_t                     dn_word
);

  logic signed [tpid_pkg::TILT_W-1:0]  target_r, target_nxt;
  logic signed [tpid_pkg::INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [tpid_pkg::ERR_W-1:0]   prev_r;
  logic                                valid_r;
  tpid_pkg::front_t                    word_r, word_nxt;

  logic signed [tpid_pkg::INTEG_W-1:0] integ_base;
  logic signed [tpid_pkg::INTEG_W:0]   integ_sum;
  logic                                take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  always_comb begin
    target_nxt = capture ? tilt : target_r;
    integ_base = capture ? '0 : integ_r;
    word_nxt.err = tpid_pkg::ERR_W'(target_nxt) - tpid_pkg::ERR_W'(tilt);
    integ_sum = (tpid_pkg::INTEG_W+1)'(integ_base) + (tpid_pkg::INTEG_W+1)'(word_nxt.err);
    // anti-windup clamp
    priority if (integ_sum > tpid_pkg::INTEG_LIM) begin
      integ_nxt = tpid_pkg::INTEG_W'(tpid_pkg::INTEG_LIM);
    end else if (integ_sum < -tpid_pkg::INTEG_LIM) begin
      integ_nxt = tpid_pkg::INTEG_W'(-tpid_pkg::INTEG_LIM);
    end else begin
      integ_nxt = integ_sum[tpid_pkg::INTEG_W-1:0];
    end
    word_nxt.integ = integ_nxt;
    word_nxt.diff  = tpid_pkg::DIFF_W'(word_nxt.err) - tpid_pkg::DIFF_W'(prev_r);
    word_nxt.stop  = (tilt >= tpid_pkg::STOP_ANGLE) || (tilt <= -tpid_pkg::STOP_ANGLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      integ_r  <= '0;
      prev_r   <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (up_ready) begin
        valid_r <= up_valid;
      end
      if (take) begin
        target_r <= target_nxt;
        integ_r  <= integ_nxt;
        prev_r   <= word_nxt.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== rtl/tpid_mult.sv =====
// product stage: the three gain multiplications
module tpid_mult (
  input  logic              clk,
  input  logic              rst_n,
  input  tpid_pkg::gains_t  gains,
  input  logic              up_valid,
  output logic              up_ready,
  input  tpid_pkg::front_t  up_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output tpid_pkg::prod_t   dn_word
);

  logic            valid_r;
  tpid_pkg::prod_t word_r, word_nxt;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    word_nxt.p    = $signed({1'b0, gains.kps}) * up_word.err;
    word_nxt.i    = $signed({1'b0, gains.ki}) * up_word.integ;
    word_nxt.d    = $signed({1'b0, gains.kds}) * up_word.diff;
    word_nxt.stop = up_word.stop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== rtl/tpid_reduce.sv =====
// sum stage: pid sum, saturation detect and magnitude scaled by 2^-16
module tpid_reduce (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  tpid_pkg::prod_t   up_word,
  output logic              dn_valid,
  input  logic              dn_ready,
  output tpid_pkg::red_t    dn_word
);

  logic                                valid_r;
  tpid_pkg::red_t                      word_r, word_nxt;
  logic signed [tpid_pkg::NUM_W-1:0]   num;
  logic [tpid_pkg::NUM_W-1:0]          mag;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    num = tpid_pkg::NUM_W'(up_word.p) + tpid_pkg::NUM_W'(up_word.i)
        + tpid_pkg::NUM_W'(up_word.d);
    word_nxt.sat_hi = num >= tpid_pkg::SUM_LIM;
    word_nxt.sat_lo = num <= -tpid_pkg::SUM_LIM;
    word_nxt.neg    = num[tpid_pkg::NUM_W-1];
    mag = word_nxt.neg ? -num : num;
    // below the limit the magnitude fits 31 bits, so this is floor(|num| / 65536)
    word_nxt.qin  = mag[16 +: tpid_pkg::QIN_W];
    word_nxt.stop = up_word.stop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== rtl/tpid_out.sv =====
// result stage: divide by 100, sign, clamps and the result register
module tpid_out (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  tpid_pkg::red_t                      up_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tpid_pkg::DRV_W-1:0]   out_wheel_drive,
  output logic signed [tpid_pkg::VAL_W-1:0]   out_controller_value,
  output logic                                out_tilt_stop
);

  logic                                            valid_r;
  logic signed [tpid_pkg::DRV_W-1:0]               drive_r, drive_nxt;
  logic signed [tpid_pkg::VAL_W-1:0]               value_r, value_nxt;
  logic                                            stop_r;
  logic [tpid_pkg::QIN_W+tpid_pkg::RECIP_W-1:0]   prod;
  logic [tpid_pkg::DRV_W-1:0]                      quot;

  assign up_ready = !valid_r || out_ready;

  always_comb begin
    prod = up_word.qin * tpid_pkg::RECIP_100;
    // quotient stays below 255 when not saturated
    quot = prod[tpid_pkg::RECIP_SH +: tpid_pkg::DRV_W];
    priority if (up_word.sat_hi) begin
      value_nxt = tpid_pkg::VAL_MAX;
    end else if (up_word.sat_lo) begin
      value_nxt = -tpid_pkg::VAL_MAX;
    end else if (up_word.neg) begin
      value_nxt = -$signed({1'b0, quot});
    end else begin
      value_nxt = $signed({1'b0, quot});
    end
    priority if (up_word.stop) begin
      drive_nxt = '0;
    end else if (value_nxt > tpid_pkg::DRV_MAX) begin
      drive_nxt = tpid_pkg::DRV_W'(tpid_pkg::DRV_MAX);
    end else if (value_nxt < -tpid_pkg::DRV_MAX) begin
      drive_nxt = tpid_pkg::DRV_W'(-tpid_pkg::DRV_MAX);
    end else begin
      drive_nxt = value_nxt[tpid_pkg::DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      drive_r <= drive_nxt;
      value_r <= value_nxt;
      stop_r  <= up_word.stop;
    end
  end

  assign out_valid            = valid_r;
  assign out_wheel_drive      = drive_r;
  assign out_controller_value = value_r;
  assign out_tilt_stop        = stop_r;

endmodule

// ===== rtl/tilt_pid_balance_controller.sv =====
// tilt balance pid controller: four-stage pipeline with clamped integral
//
// input channel: one pitch word per handshake (in_tilt_sample in 1/256 degree,
// in_capture_target to take this pitch as the new target and clear the integral).
// result channel: one word per input word, in order: out_wheel_drive,
// out_controller_value (clamped pid sum) and out_tilt_stop.
// gains are written on cfg_we with cfg_index 0 (kp), 1 (ki), 2 (kd); kp data is Q7.8,
// ki and kd data Q4.8; write them only while no word is in flight.
// path: a taken input word is registered in the input/state stage, multiply stage,
// sum stage and result register in turn before its result is valid.
// throughput: one word per cycle when out_ready is high; integral and previous error
// update in the input stage, so each word sees the state the previous one left.
// every stage has its own valid bit and holds when the next is full and stalled,
// so with out_ready low up to four words stay buffered and in_ready drops only
// when all stages hold a word.
// reset: gains return to 30.0, 0.5, 1.5; target, integral and previous error clear;
// the pipeline empties.
module tilt_pid_balance_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [tpid_pkg::TILT_W-1:0]  in_tilt_sample,
  input  logic                                in_capture_target,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tpid_pkg::DRV_W-1:0]   out_wheel_drive,
  output logic signed [tpid_pkg::VAL_W-1:0]   out_controller_value,
  output logic                                out_tilt_stop,
  input  logic                                cfg_we,
  input  logic [tpid_pkg::IDX_W-1:0]          cfg_index,
  input  logic [tpid_pkg::CFG_W-1:0]          cfg_wdata
);

  tpid_pkg::gains_t gains;
  tpid_pkg::front_t front_word;
  tpid_pkg::prod_t  prod_word;
  tpid_pkg::red_t   red_word;
  logic front_valid, front_ready;
  logic prod_valid, prod_ready;
  logic red_valid, red_ready;

  tpid_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .gains     (gains)
  );

  tpid_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .tilt     (in_tilt_sample),
    .capture  (in_capture_target),
    .dn_valid (front_valid),
    .dn_ready (front_ready),
    .dn_word  (front_word)
  );

  tpid_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .gains    (gains),
    .up_valid (front_valid),
    .up_ready (front_ready),
    .up_word  (front_word),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_word  (prod_word)
  );

  tpid_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_word  (prod_word),
    .dn_valid (red_valid),
    .dn_ready (red_ready),
    .dn_word  (red_word)
  );

  tpid_out u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .up_valid             (red_valid),
    .up_ready             (red_ready),
    .up_word              (red_word),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_wheel_drive      (out_wheel_drive),
    .out_controller_value (out_controller_value),
    .out_tilt_stop        (out_tilt_stop)
  );

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stop_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_tilt_stop) |-> (out_wheel_drive == '0))
    else $error("drive not zero during tilt stop");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_controller_value <= tpid_pkg::VAL_MAX) &&
                  (out_controller_value >= -tpid_pkg::VAL_MAX))
    else $error("controller value out of range");

  a_drive_follows_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_tilt_stop && (out_controller_value <= tpid_pkg::DRV_MAX) &&
     (out_controller_value >= -tpid_pkg::DRV_MAX))
      |-> (tpid_pkg::VAL_W'(out_wheel_drive) == out_controller_value))
    else $error("drive differs from unclamped controller value");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && front_valid && prod_valid && red_valid) |-> !in_ready)
    else $error("input taken while pipeline full and stalled");
`endif

endmodule
